// ===== rtl/jes_pkg.sv =====
// ----------------------------------------------------------------------------
// jes_pkg
// Constants and helper functions of the fixed-point Jacobi eigensolver.
// ----------------------------------------------------------------------------
package jes_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXROT = 2'd2;

  localparam logic [3:0] SIZE_RESET = 4'd8;
  localparam logic [47:0] THRESH_RESET = 48'd4295;
  localparam logic [15:0] MAXROT_RESET = 16'd4096;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [63:0] INV_GAIN = 64'sd652032874;
  localparam logic signed [31:0] QUARTER_PI = 32'sd843314857;
  localparam int unsigned PRE_SHIFT = 24;
  localparam logic signed [65:0] MIX_ROUND = 66'sd536870912;
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic [31:0] atan_lut(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0: r = 32'h3243F6A8;
      5'd1: r = 32'h1DAC6705;
      5'd2: r = 32'h0FADBAFC;
      5'd3: r = 32'h07F56EA6;
      5'd4: r = 32'h03FEAB76;
      5'd5: r = 32'h01FFD55B;
      5'd6: r = 32'h00FFFAAA;
      5'd7: r = 32'h007FFF55;
      5'd8: r = 32'h003FFFEA;
      5'd9: r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// ===== rtl/jes_ram.sv =====
// ----------------------------------------------------------------------------
// jes_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module jes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/jacobi_eigen_solver.sv =====
// ----------------------------------------------------------------------------
// jacobi_eigen_solver
// Jacobi eigensolver for a symmetric Q16.16 matrix of order 2..8.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle in row-major order while the input is not
// stalled. After the last one the block stalls its input and solves: it
// sets the eigenvector store to identity, then each rotation runs a pivot
// scan, a column search, operand reads, the shared CORDIC unit and the row
// and column updates, all paced by the single multiplier and the one read
// port of each store. The solve ends with one more scan, and each of the n
// results is then read out of the stores before it is offered on the output.
module jacobi_eigen_solver #(
  parameter int unsigned MAX_SIZE = 8,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             element_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             eigenvalue_o,
  output logic signed [31:0]             vec_comp0_o,
  output logic signed [31:0]             vec_comp1_o,
  output logic signed [31:0]             vec_comp2_o,
  output logic signed [31:0]             vec_comp3_o,
  output logic signed [31:0]             vec_comp4_o,
  output logic signed [31:0]             vec_comp5_o,
  output logic signed [31:0]             vec_comp6_o,
  output logic signed [31:0]             vec_comp7_o,
  output logic [15:0]                    rotation_count_o,
  output logic                           converged_o,
  output logic                           last_o
);
  import jes_pkg::*;

  localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH = 1 << ADDR_W;
  localparam logic [4:0] CK_LAST = 5'(CORDIC_STEPS - 1);

  typedef enum logic [20:0] {
    ST_LOAD    = 21'd1,
    ST_VINIT   = 21'd2,
    ST_SC_RD   = 21'd4,
    ST_SC_MUL  = 21'd8,
    ST_SC_ACC  = 21'd16,
    ST_DECIDE  = 21'd32,
    ST_CS_RD   = 21'd64,
    ST_CS_CMP  = 21'd128,
    ST_AN_RD   = 21'd256,
    ST_AN_CAP  = 21'd512,
    ST_AN_SET  = 21'd1024,
    ST_CORDIC  = 21'd2048,
    ST_UP_RU   = 21'd4096,
    ST_UP_RV   = 21'd8192,
    ST_UP_M1   = 21'd16384,
    ST_UP_M2   = 21'd32768,
    ST_UP_W1   = 21'd65536,
    ST_UP_M4   = 21'd131072,
    ST_UP_W2   = 21'd262144,
    ST_OUT_RD  = 21'd524288,
    ST_OUT_CAP = 21'd1048576
  } state_e;

  state_e state_q, state_d;

  logic [3:0] size_q;
  logic [47:0] thresh_q;
  logic [15:0] maxrot_q;
  logic [CNT_W-1:0] n_cur, n_q;
  logic [IDX_W-1:0] ncur_m1, n_m1;

  logic [IDX_W-1:0] ld_row_q, ld_col_q, i_q, j_q, k_q, prow_q, pcol_q;
  logic [CNT_W-1:0] ocnt_q;
  logic [1:0] acnt_q, pass_q;
  logic [4:0] ck_q;
  logic [ADDR_W-1:0] vinit_q;
  logic [15:0] rot_q;
  logic conv_q, show_q, mode_rot_q;
  logic [63:0] off_q, rsum_q, best_q;
  logic [31:0] besta_q;
  logic signed [31:0] aij_q, aii_q, u_q, v_q, c_q, s_q;
  logic signed [63:0] prod_q, acc_q, cx_q, cy_q;
  logic signed [35:0] cz_q;
  logic signed [31:0] eig_q;
  logic signed [31:0] vec_q [8];

  logic a_we, v_we;
  logic [ADDR_W-1:0] a_waddr, v_waddr, raddr, addr_u, addr_v;
  logic [31:0] a_wdata, v_wdata, a_rdata, v_rdata;
  logic signed [31:0] rd;
  logic sel_v;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_full;
  logic signed [65:0] mix_sum, mix_sh;
  logic signed [31:0] mix_res;

  logic signed [63:0] dx, dy, cx_n, cy_n;
  logic signed [35:0] ct, cz_n, cz_half;
  logic sigma;

  logic [63:0] sq, rsum_n;
  logic [31:0] absv;
  logic signed [32:0] diff;
  logic signed [33:0] dabs, ysgn;

  always_comb begin
    n_cur = CNT_W'(size_q);
    if (size_q < 4'd2) begin
      n_cur = CNT_W'(2);
    end else if (32'(size_q) > MAX_SIZE) begin
      n_cur = CNT_W'(MAX_SIZE);
    end
  end
  assign ncur_m1 = IDX_W'(n_cur - CNT_W'(1));
  assign n_m1 = IDX_W'(n_q - CNT_W'(1));

  assign addr_u = (pass_q == 2'd1) ? {prow_q, k_q} : {k_q, prow_q};
  assign addr_v = (pass_q == 2'd1) ? {pcol_q, k_q} : {k_q, pcol_q};

  always_comb begin
    raddr = addr_u;
    unique case (state_q)
      ST_SC_RD: raddr = {i_q, j_q};
      ST_CS_RD: raddr = {prow_q, j_q};
      ST_AN_RD, ST_AN_CAP: begin
        if (acnt_q == 2'd0) begin
          raddr = {prow_q, pcol_q};
        end else if (acnt_q == 2'd1) begin
          raddr = {prow_q, prow_q};
        end else begin
          raddr = {pcol_q, pcol_q};
        end
      end
      ST_UP_RV: raddr = addr_v;
      ST_OUT_RD: begin
        if (ocnt_q == '0) begin
          raddr = {k_q, k_q};
        end else begin
          raddr = {IDX_W'(ocnt_q - CNT_W'(1)), k_q};
        end
      end
      default: raddr = addr_u;
    endcase
  end

  assign sel_v = ((pass_q == 2'd2) && (state_q == ST_UP_RV || state_q == ST_UP_M1))
               || (state_q == ST_OUT_CAP && ocnt_q != '0);
  assign rd = sel_v ? $signed(v_rdata) : $signed(a_rdata);

  always_comb begin
    mul_a = rd;
    mul_b = 33'(rd);
    unique case (state_q)
      ST_UP_M1: begin
        mul_a = u_q;
        mul_b = 33'(c_q);
      end
      ST_UP_M2: begin
        mul_a = v_q;
        mul_b = 33'(s_q);
      end
      ST_UP_W1: begin
        mul_a = u_q;
        mul_b = -33'(s_q);
      end
      ST_UP_M4: begin
        mul_a = v_q;
        mul_b = 33'(c_q);
      end
      default: begin
        mul_a = rd;
        mul_b = 33'(rd);
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  always_comb begin
    mix_sum = acc_q + prod_q + MIX_ROUND;
    mix_sh = mix_sum >>> 30;
    if (mix_sh > SAT_MAX) begin
      mix_res = 32'sh7FFFFFFF;
    end else if (mix_sh < SAT_MIN) begin
      mix_res = 32'sh80000000;
    end else begin
      mix_res = mix_sh[31:0];
    end
  end

  always_comb begin
    dx = cx_q >>> ck_q;
    dy = cy_q >>> ck_q;
    ct = 36'(atan_lut(ck_q));
    sigma = mode_rot_q ? !cz_q[35] : cy_q[63];
    cx_n = sigma ? cx_q - dy : cx_q + dy;
    cy_n = sigma ? cy_q + dx : cy_q - dx;
    cz_n = sigma ? cz_q - ct : cz_q + ct;
    cz_half = cz_n >>> 1;
  end

  assign sq = prod_q;
  assign rsum_n = (i_q != j_q) ? sat_add64(rsum_q, sq) : rsum_q;
  assign absv = rd[31] ? 32'(-rd) : 32'(rd);
  assign diff = 33'(aii_q) - 33'(rd);
  assign dabs = diff[32] ? -34'(diff) : 34'(diff);
  assign ysgn = diff[32] ? -34'($signed({aij_q, 1'b0})) : 34'($signed({aij_q, 1'b0}));

  always_comb begin
    a_we = 1'b0;
    a_waddr = {ld_row_q, ld_col_q};
    a_wdata = element_value_i;
    v_we = 1'b0;
    v_waddr = vinit_q;
    v_wdata = (vinit_q[ADDR_W-1:IDX_W] == vinit_q[IDX_W-1:0]) ? ONE_Q16 : '0;
    if (state_q == ST_LOAD) begin
      a_we = in_valid_i && !cfg_we_i;
    end else if (state_q == ST_UP_W1 || state_q == ST_UP_W2) begin
      a_waddr = (state_q == ST_UP_W1) ? addr_u : addr_v;
      a_wdata = mix_res;
      v_waddr = a_waddr;
      v_wdata = mix_res;
      a_we = (pass_q != 2'd2);
      v_we = (pass_q == 2'd2);
    end else if (state_q == ST_VINIT) begin
      v_we = 1'b1;
    end
  end

  jes_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  jes_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (raddr),
    .rdata_o (v_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && !cfg_we_i && ld_col_q == ncur_m1 && ld_row_q == ncur_m1) begin
          state_d = ST_VINIT;
        end
      end
      ST_VINIT: if (vinit_q == '1) state_d = ST_SC_RD;
      ST_SC_RD: state_d = ST_SC_MUL;
      ST_SC_MUL: state_d = ST_SC_ACC;
      ST_SC_ACC: begin
        state_d = (j_q == n_m1 && i_q == n_m1) ? ST_DECIDE : ST_SC_RD;
      end
      ST_DECIDE: begin
        if (off_q <= 64'(thresh_q) || rot_q >= maxrot_q) begin
          state_d = ST_OUT_RD;
        end else begin
          state_d = ST_CS_RD;
        end
      end
      ST_CS_RD: state_d = ST_CS_CMP;
      ST_CS_CMP: state_d = (j_q == n_m1) ? ST_AN_RD : ST_CS_RD;
      ST_AN_RD: state_d = ST_AN_CAP;
      ST_AN_CAP: state_d = (acnt_q == 2'd2) ? ST_AN_SET : ST_AN_RD;
      ST_AN_SET: state_d = ST_CORDIC;
      ST_CORDIC: if (mode_rot_q && ck_q == CK_LAST) state_d = ST_UP_RU;
      ST_UP_RU: state_d = ST_UP_RV;
      ST_UP_RV: state_d = ST_UP_M1;
      ST_UP_M1: state_d = ST_UP_M2;
      ST_UP_M2: state_d = ST_UP_W1;
      ST_UP_W1: state_d = ST_UP_M4;
      ST_UP_M4: state_d = ST_UP_W2;
      ST_UP_W2: begin
        state_d = (k_q == n_m1 && pass_q == 2'd2) ? ST_SC_RD : ST_UP_RU;
      end
      ST_OUT_RD: begin
        if (show_q) begin
          if (!out_stall_i) begin
            state_d = (k_q == n_m1) ? ST_LOAD : ST_OUT_RD;
          end
        end else begin
          state_d = ST_OUT_CAP;
        end
      end
      ST_OUT_CAP: state_d = ST_OUT_RD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      size_q <= SIZE_RESET;
      thresh_q <= THRESH_RESET;
      maxrot_q <= MAXROT_RESET;
      n_q <= CNT_W'(2);
      ld_row_q <= '0;
      ld_col_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      prow_q <= '0;
      pcol_q <= '0;
      ocnt_q <= '0;
      acnt_q <= '0;
      pass_q <= '0;
      ck_q <= '0;
      vinit_q <= '0;
      rot_q <= '0;
      conv_q <= 1'b0;
      show_q <= 1'b0;
      mode_rot_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SIZE) begin
          size_q <= cfg_wdata_i[3:0];
          ld_row_q <= '0;
          ld_col_q <= '0;
        end else if (cfg_idx_i == CFG_THRESH) begin
          thresh_q <= cfg_wdata_i;
        end else if (cfg_idx_i == CFG_MAXROT) begin
          maxrot_q <= cfg_wdata_i[15:0];
        end
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_valid_i && !cfg_we_i) begin
            if (ld_col_q == ncur_m1) begin
              ld_col_q <= '0;
              if (ld_row_q == ncur_m1) begin
                ld_row_q <= '0;
                n_q <= n_cur;
                vinit_q <= '0;
                rot_q <= '0;
              end else begin
                ld_row_q <= ld_row_q + IDX_W'(1);
              end
            end else begin
              ld_col_q <= ld_col_q + IDX_W'(1);
            end
          end
        end
        ST_VINIT: begin
          vinit_q <= vinit_q + ADDR_W'(1);
          i_q <= '0;
          j_q <= '0;
        end
        ST_SC_ACC: begin
          if (j_q == n_m1) begin
            j_q <= '0;
            i_q <= i_q + IDX_W'(1);
            if (rsum_n >= best_q) begin
              prow_q <= i_q;
            end
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_DECIDE: begin
          j_q <= '0;
          k_q <= '0;
          ocnt_q <= '0;
          show_q <= 1'b0;
          conv_q <= (off_q <= 64'(thresh_q));
        end
        ST_CS_CMP: begin
          if (j_q != prow_q && absv >= besta_q) begin
            pcol_q <= j_q;
          end
          j_q <= j_q + IDX_W'(1);
          acnt_q <= '0;
        end
        ST_AN_CAP: acnt_q <= acnt_q + 2'd1;
        ST_AN_SET: begin
          ck_q <= '0;
          mode_rot_q <= (diff == '0);
        end
        ST_CORDIC: begin
          if (ck_q == CK_LAST) begin
            ck_q <= '0;
            if (!mode_rot_q) begin
              mode_rot_q <= 1'b1;
            end else begin
              k_q <= '0;
              pass_q <= '0;
            end
          end else begin
            ck_q <= ck_q + 5'd1;
          end
        end
        ST_UP_W2: begin
          if (k_q == n_m1) begin
            k_q <= '0;
            if (pass_q == 2'd2) begin
              rot_q <= rot_q + 16'd1;
              i_q <= '0;
              j_q <= '0;
            end else begin
              pass_q <= pass_q + 2'd1;
            end
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_OUT_RD: begin
          if (show_q && !out_stall_i) begin
            show_q <= 1'b0;
            ocnt_q <= '0;
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_OUT_CAP: begin
          if (ocnt_q == n_q) begin
            show_q <= 1'b1;
          end else begin
            ocnt_q <= ocnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    unique case (state_q)
      ST_VINIT: begin
        off_q <= '0;
        rsum_q <= '0;
        best_q <= '0;
      end
      ST_SC_ACC: begin
        if (j_q > i_q) begin
          off_q <= sat_add64(off_q, {sq[62:0], 1'b0});
        end
        if (j_q == n_m1) begin
          rsum_q <= '0;
          if (rsum_n >= best_q) begin
            best_q <= rsum_n;
          end
        end else begin
          rsum_q <= rsum_n;
        end
      end
      ST_DECIDE: begin
        besta_q <= '0;
        for (int m = 0; m < 8; m++) begin
          vec_q[m] <= '0;
        end
      end
      ST_CS_CMP: begin
        if (j_q != prow_q && absv >= besta_q) begin
          besta_q <= absv;
        end
      end
      ST_AN_CAP: begin
        if (acnt_q == 2'd0) begin
          aij_q <= rd;
        end else if (acnt_q == 2'd1) begin
          aii_q <= rd;
        end
      end
      ST_AN_SET: begin
        if (diff == '0) begin
          cx_q <= INV_GAIN;
          cy_q <= '0;
          cz_q <= aij_q[31] ? -36'(QUARTER_PI) : 36'(QUARTER_PI);
        end else begin
          cx_q <= {{6{dabs[33]}}, dabs, {PRE_SHIFT{1'b0}}};
          cy_q <= {{6{ysgn[33]}}, ysgn, {PRE_SHIFT{1'b0}}};
          cz_q <= '0;
        end
      end
      ST_CORDIC: begin
        if (ck_q == CK_LAST && !mode_rot_q) begin
          cx_q <= INV_GAIN;
          cy_q <= '0;
          cz_q <= 36'(signed'(cz_half[31:0]));
        end else begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          if (ck_q == CK_LAST) begin
            c_q <= cx_n[31:0];
            s_q <= cy_n[31:0];
          end
        end
        off_q <= '0;
        rsum_q <= '0;
        best_q <= '0;
      end
      ST_UP_RV: u_q <= rd;
      ST_UP_M1: v_q <= rd;
      ST_UP_M2: acc_q <= prod_q;
      ST_UP_M4: acc_q <= prod_q;
      ST_OUT_RD: begin
        if (show_q && !out_stall_i) begin
          for (int m = 0; m < 8; m++) begin
            vec_q[m] <= '0;
          end
        end
      end
      ST_OUT_CAP: begin
        if (ocnt_q == '0) begin
          eig_q <= rd;
        end else begin
          vec_q[3'(ocnt_q - CNT_W'(1))] <= rd;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_LOAD) || cfg_we_i;
  assign out_valid_o = (state_q == ST_OUT_RD) && show_q;
  assign eigenvalue_o = eig_q;
  assign vec_comp0_o = vec_q[0];
  assign vec_comp1_o = vec_q[1];
  assign vec_comp2_o = vec_q[2];
  assign vec_comp3_o = vec_q[3];
  assign vec_comp4_o = vec_q[4];
  assign vec_comp5_o = vec_q[5];
  assign vec_comp6_o = vec_q[6];
  assign vec_comp7_o = vec_q[7];
  assign rotation_count_o = rot_q;
  assign converged_o = conv_q;
  assign last_o = (k_q == n_m1);

endmodule

// ===== dv/jacobi_eigen_solver_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_eigen_solver_test
// Self-checking bench for the Jacobi eigensolver. Matrices are streamed in,
// one element per item. A bit-exact fixed-point solver in the bench predicts
// every eigenpair, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module jacobi_eigen_solver_test;
  import jes_pkg::*;

  typedef enum logic {OP_ELEM, OP_CFG} op_kind_e;

  typedef struct {
    op_kind_e         kind;
    logic [1:0]       idx;
    logic [47:0]      data;
  } stim_op_t;

  typedef struct {
    logic [31:0] eig;
    logic [31:0] vec [8];
    logic [15:0] rcount;
    logic        conv;
    logic        last;
  } eigenpair_t;

  localparam int CORDIC_N = 24;
  localparam int QUIET_CYCLES = 40;
  localparam longint ATAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [31:0]      element_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [31:0]      eigenvalue_o;
  logic signed [31:0]      vec_comp0_o, vec_comp1_o, vec_comp2_o, vec_comp3_o;
  logic signed [31:0]      vec_comp4_o, vec_comp5_o, vec_comp6_o, vec_comp7_o;
  logic [15:0]             rotation_count_o;
  logic                    converged_o;
  logic                    last_o;

  jacobi_eigen_solver DUT (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  stim_op_t           pending_ops [$];
  eigenpair_t         expected_pairs [$];
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 elem_total = 0;

  logic signed [31:0] mat_a [64];
  logic signed [31:0] mat_v [64];
  int                 load_pos = 0;
  logic [3:0]         cur_size = SIZE_RESET;
  logic [47:0]        cur_thresh = THRESH_RESET;
  logic [15:0]        cur_maxrot = MAXROT_RESET;

  function automatic int matrix_order(logic [3:0] s);
    if (s < 2) return 2;
    if (s > 8) return 8;
    return int'(s);
  endfunction

  function automatic longint unsigned square_q32(logic signed [31:0] v);
    longint w;
    w = v;
    return w * w;
  endfunction

  function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
    longint unsigned r;
    r = a + b;
    return (r < a) ? 64'hFFFF_FFFF_FFFF_FFFF : r;
  endfunction

  function automatic logic signed [31:0] rot_mix(logic signed [31:0] p, longint cp,
                                                  logic signed [31:0] q, longint cq);
    longint acc;
    acc = (longint'(p) * cp + longint'(q) * cq + (longint'(1) << 29)) >>> 30;
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] half_angle(logic signed [31:0] aij,
                                                     logic signed [31:0] aii,
                                                     logic signed [31:0] ajj);
    longint x, y, z, dx, dy;
    x = longint'(aii) - longint'(ajj);
    y = 2 * longint'(aij);
    z = 0;
    if (x == 0) return (y >= 0) ? QUARTER_PI : -QUARTER_PI;
    if (x < 0) begin
      x = -x;
      y = -y;
    end
    x = x <<< PRE_SHIFT;
    y = y <<< PRE_SHIFT;
    for (int k = 0; k < CORDIC_N; k++) begin
      dx = x >>> k;
      dy = y >>> k;
      if (y >= 0) begin
        x += dy; y -= dx; z += ATAN_Q30[k];
      end else begin
        x -= dy; y += dx; z -= ATAN_Q30[k];
      end
    end
    z = z >>> 1;
    return z[31:0];
  endfunction

  function automatic longint unsigned off_diag_sum(int n);
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        sum = add_sat(sum, add_sat(square_q32(mat_a[i*8+j]), square_q32(mat_a[i*8+j])));
    return sum;
  endfunction

  function automatic void apply_rotation(int n);
    longint unsigned best, r;
    logic [31:0] best_mag, mag;
    int p, q;
    longint x, y, z, dx, dy;
    logic signed [31:0] theta, u, w;
    best = 0;
    best_mag = 0;
    p = 0;
    q = 0;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < n; j++)
        if (j != i) r = add_sat(r, square_q32(mat_a[i*8+j]));
      if (r >= best) begin
        best = r;
        p = i;
      end
    end
    for (int j = 0; j < n; j++) begin
      mag = (mat_a[p*8+j] < 0) ? -mat_a[p*8+j] : mat_a[p*8+j];
      if (j != p && mag >= best_mag) begin
        best_mag = mag;
        q = j;
      end
    end
    theta = half_angle(mat_a[p*8+q], mat_a[p*8+p], mat_a[q*8+q]);
    x = INV_GAIN;
    y = 0;
    z = theta;
    for (int k = 0; k < CORDIC_N; k++) begin
      dx = x >>> k;
      dy = y >>> k;
      if (z >= 0) begin
        x -= dy; y += dx; z -= ATAN_Q30[k];
      end else begin
        x += dy; y -= dx; z += ATAN_Q30[k];
      end
    end
    for (int k = 0; k < n; k++) begin
      u = mat_a[k*8+p];
      w = mat_a[k*8+q];
      mat_a[k*8+p] = rot_mix(u, x, w, y);
      mat_a[k*8+q] = rot_mix(u, -y, w, x);
    end
    for (int k = 0; k < n; k++) begin
      u = mat_a[p*8+k];
      w = mat_a[q*8+k];
      mat_a[p*8+k] = rot_mix(u, x, w, y);
      mat_a[q*8+k] = rot_mix(u, -y, w, x);
    end
    for (int k = 0; k < n; k++) begin
      u = mat_v[k*8+p];
      w = mat_v[k*8+q];
      mat_v[k*8+p] = rot_mix(u, x, w, y);
      mat_v[k*8+q] = rot_mix(u, -y, w, x);
    end
  endfunction

  // Stores one element; the last element of a matrix runs the whole solve and
  // queues its eigenpairs.
  function automatic void load_element(logic signed [31:0] value);
    int n, rc;
    logic conv;
    eigenpair_t ep;
    n = matrix_order(cur_size);
    if (load_pos >= n * n) load_pos = 0;
    mat_a[(load_pos / n) * 8 + (load_pos % n)] = value;
    load_pos++;
    if (load_pos < n * n) return;
    load_pos = 0;
    for (int i = 0; i < 64; i++) mat_v[i] = (i / 8 == i % 8) ? ONE_Q16 : 32'sd0;
    rc = 0;
    forever begin
      if (off_diag_sum(n) <= {16'd0, cur_thresh}) begin
        conv = 1'b1;
        break;
      end
      if (rc >= cur_maxrot) begin
        conv = 1'b0;
        break;
      end
      apply_rotation(n);
      rc++;
    end
    for (int k = 0; k < n; k++) begin
      ep.eig = mat_a[k*8+k];
      for (int m = 0; m < 8; m++) ep.vec[m] = (m < n) ? mat_v[m*8+k] : 32'd0;
      ep.rcount = rc[15:0];
      ep.conv = conv;
      ep.last = (k == n - 1);
      expected_pairs.push_back(ep);
    end
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [47:0] data);
    stim_op_t op;
    op.kind = OP_CFG;
    op.idx = idx;
    op.data = data;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_elem(logic signed [31:0] v);
    stim_op_t op;
    op.kind = OP_ELEM;
    op.idx = '0;
    op.data = {{16{v[31]}}, v};
    pending_ops.push_back(op);
    elem_total++;
  endfunction

  function automatic logic signed [31:0] random_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 1048576)) - 32'sd524288;
    if (r < 90) return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
    return $urandom;
  endfunction

  function automatic void add_random_matrix(int n, bit symmetric);
    logic signed [31:0] m [64];
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        m[i*8+j] = (symmetric && j < i) ? m[j*8+i] : random_element();
    for (int i = 0; i < n * n; i++) add_elem(m[(i / n) * 8 + (i % n)]);
  endfunction

  function automatic void add_list(logic signed [31:0] v [$]);
    foreach (v[i]) add_elem(v[i]);
  endfunction

  function automatic void build_stimulus();
    int r, n, size_code;
    add_cfg(CFG_SIZE, 48'd2);
    add_cfg(CFG_THRESH, 48'd4295);
    add_cfg(CFG_MAXROT, 48'd64);
    add_list('{32'sh10000, 32'sh20000, 32'sh20000, 32'sh10000});
    add_list('{32'sh10000, -32'sh20000, -32'sh20000, 32'sh10000});
    add_list('{32'sh30000, 32'sh0, 32'sh0, -32'sh50000});
    add_list('{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
    add_cfg(CFG_MAXROT, 48'd0);
    add_list('{32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000});
    add_cfg(CFG_THRESH, 48'hFFFF_FFFF_FFFF);
    add_cfg(CFG_MAXROT, 48'd65535);
    add_random_matrix(2, 1'b1);
    add_cfg(CFG_THRESH, 48'd0);
    add_cfg(CFG_MAXROT, 48'd5);
    add_cfg(CFG_SIZE, 48'd3);
    add_list('{32'sh10000, 32'sh10000, 32'sh10000});
    add_cfg(CFG_SIZE, 48'd1);
    add_list('{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000});
    while (elem_total < 100) begin
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 45) size_code = 2;
        else if (r < 75) size_code = 3;
        else if (r < 88) size_code = 4;
        else if (r < 94) size_code = $urandom_range(5, 7);
        else if (r < 97) size_code = $urandom_range(8, 15);
        else size_code = $urandom_range(0, 1);
        add_cfg(CFG_SIZE, 48'(size_code));
        cur_size = size_code[3:0];
      end
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 5) add_cfg(CFG_THRESH, 48'd4295);
        else if (r < 8) add_cfg(CFG_THRESH, 48'($urandom_range(0, 1 << 30)));
        else add_cfg(CFG_THRESH, 48'({$urandom, $urandom}));
      end
      if ($urandom_range(0, 2) == 0) add_cfg(CFG_MAXROT, 48'($urandom_range(1, 40)));
      n = matrix_order(cur_size);
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < $urandom_range(1, n * n - 1); i++) add_elem(random_element());
        add_cfg(CFG_SIZE, 48'(cur_size));
      end
      add_random_matrix(n, $urandom_range(0, 9) != 0);
    end
    cur_size = SIZE_RESET;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid, next_we;
    int r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      next_we = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        load_element(element_value_i);
        next_valid = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 60) gap_left = 0;
        else if (r < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(10, 40);
      end
      quiet_cycles = (expected_pairs.size() == 0 && !next_valid) ? quiet_cycles + 1 : 0;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          if (pending_ops[0].kind == OP_CFG) begin
            if (quiet_cycles >= QUIET_CYCLES) begin
              case (pending_ops[0].idx)
                CFG_SIZE: begin
                  cur_size = pending_ops[0].data[3:0];
                  load_pos = 0;
                end
                CFG_THRESH: cur_thresh = pending_ops[0].data;
                CFG_MAXROT: cur_maxrot = pending_ops[0].data[15:0];
                default: ;
              endcase
              next_we = 1'b1;
              cfg_idx_i <= pending_ops[0].idx;
              cfg_wdata_i <= pending_ops[0].data;
              void'(pending_ops.pop_front());
            end
          end else begin
            next_valid = 1'b1;
            element_value_i <= pending_ops[0].data[31:0];
            void'(pending_ops.pop_front());
          end
        end
      end
      in_valid_i <= next_valid;
      cfg_we_i <= next_we;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eigenpair_t ep;
    logic [31:0] vec_got [8];
    int r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected eigenpair: eigenvalue %h", eigenvalue_o);
          fail_count++;
        end else begin
          ep = expected_pairs.pop_front();
          vec_got = '{vec_comp0_o, vec_comp1_o, vec_comp2_o, vec_comp3_o,
                      vec_comp4_o, vec_comp5_o, vec_comp6_o, vec_comp7_o};
          check_field("eigenvalue", ep.eig, eigenvalue_o);
          for (int m = 0; m < 8; m++)
            check_field($sformatf("vec_comp%0d", m), ep.vec[m], vec_got[m]);
          check_field("rotation_count", 32'(ep.rcount), 32'(rotation_count_o));
          check_field("converged", 32'(ep.conv), 32'(converged_o));
          check_field("last", 32'(ep.last), 32'(last_o));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 80);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_ops.size() > 0 || expected_pairs.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && expected_pairs.size() == 0) begin
      $display("** jacobi_eigen_solver: PASSED **");
    end else begin
      $display("** jacobi_eigen_solver: FAILED **");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("** jacobi_eigen_solver: FAILED **");
    $finish;
  end

endmodule
